[rtl/core/pattern_or_timed_pulse_trigger_defines.svh]
// Assertion macros for the trigger block.
// Both expect signals named clk and arst_n in the enclosing scope.
`ifndef PATTERN_OR_TIMED_PULSE_TRIGGER_DEFINES_SVH
`define PATTERN_OR_TIMED_PULSE_TRIGGER_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a property on every rising edge, outside reset
`define POT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Check that an expression never holds, outside reset
`define POT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define POT_ASSERT(lbl, prop, msg)
`define POT_NEVER(lbl, expr, msg)
`endif

`endif

[rtl/core/pot_pkg.sv]
package pot_pkg;

	// Fixed field and register widths
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int PAT_W      = 64;
	localparam int LEN_W      = 4;
	localparam int DLY_W      = 20;

	// Input commands
	localparam logic [1:0] CMD_BYTE  = 2'd0;
	localparam logic [1:0] CMD_TICK  = 2'd1;
	localparam logic [1:0] CMD_REARM = 2'd2;

	// Sequence phases
	localparam logic [1:0] PH_WAIT   = 2'd0;
	localparam logic [1:0] PH_DELAY  = 2'd1;
	localparam logic [1:0] PH_ACTIVE = 2'd2;
	localparam logic [1:0] PH_DONE   = 2'd3;

	// Trigger modes
	localparam logic MODE_TIMED  = 1'b0;
	localparam logic MODE_SERIAL = 1'b1;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MODE         = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_PAT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_LEN    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_PAT     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_LEN     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_START_DELAY  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_DUR   = 3'd6;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] rx_byte;
		logic       power_sensed;
	} in_item_t;

	typedef struct packed {
		logic       pulse_active;
		logic [1:0] phase;
		logic       started;
		logic       stopped;
	} out_item_t;

	// Configuration as seen by the datapath, lengths already clamped
	typedef struct packed {
		logic             trigger_mode;
		logic [PAT_W-1:0] start_pattern;
		logic [LEN_W-1:0] start_len;
		logic [PAT_W-1:0] stop_pattern;
		logic [LEN_W-1:0] stop_len;
	} cfg_t;

	// Window control from the sequencer
	typedef struct packed {
		logic shift;
		logic clear;
	} win_ctl_t;

	// Pattern match flags from the window
	typedef struct packed {
		logic start_hit;
		logic stop_hit;
	} win_hit_t;

endpackage

[rtl/core/pot_if.sv]
// Input item channel
interface pot_in_if;
	import pot_pkg::*;

	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// Result item channel
interface pot_out_if;
	import pot_pkg::*;

	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/core/pattern_or_timed_pulse_trigger.sv]
// Channel   Modport  Transaction
// item      sink     cmd, rx_byte, power_sensed
// result    source   pulse_active, phase, started, stopped
// cfg_*     write    register index and data, no read-back
//
// An accepted transaction is held in the input register, then passes through the
// sequencer into the result register.
// One transaction is accepted per cycle, sustained, while the result side is ready.
// Reset clears the window, the sequence and the registers to their defaults.
// A stalled result holds; the input register keeps filling until it too is full.
`include "pattern_or_timed_pulse_trigger_defines.svh"

module pattern_or_timed_pulse_trigger #(
	parameter int PATTERN_BYTES = 8,
	parameter int DELAY_BITS    = 20
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [pot_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pot_pkg::CFG_DATA_W-1:0] cfg_wdata,
	pot_in_if.sink                         item,
	pot_out_if.source                      result
);
	import pot_pkg::*;

	cfg_t                  cfg;
	logic [DELAY_BITS-1:0] start_delay;
	logic [DELAY_BITS-1:0] active_delay;

	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t result_s2;
	logic      valid_s2;
	logic      advance;

	win_ctl_t  win_ctl;
	win_hit_t  hit;
	out_item_t next_result;

	// Move the input register on when the result register is free or draining
	assign advance    = valid_s1 & (~valid_s2 | result.ready);
	assign item.ready = ~valid_s1 | advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1 <= item.data;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= next_result;
		end
	end

	assign result.valid = valid_s2;
	assign result.data  = result_s2;

	pot_cfg #(
		.PATTERN_BYTES (PATTERN_BYTES),
		.DELAY_BITS    (DELAY_BITS)
	) u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.cfg          (cfg),
		.start_delay  (start_delay),
		.active_delay (active_delay)
	);

	pot_window #(
		.PATTERN_BYTES (PATTERN_BYTES)
	) u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (win_ctl),
		.rx_byte (item_s1.rx_byte),
		.cfg     (cfg),
		.hit     (hit)
	);

	pot_ctrl #(
		.DELAY_BITS (DELAY_BITS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.item         (item_s1),
		.trigger_mode (cfg.trigger_mode),
		.start_delay  (start_delay),
		.active_delay (active_delay),
		.hit          (hit),
		.win_ctl      (win_ctl),
		.result       (next_result)
	);

	// Output is driven exactly while the sequence is in the active phase
	`POT_ASSERT(a_pulse_phase, result.valid |-> (result.data.pulse_active == (result.data.phase == PH_ACTIVE)), "pulse_active disagrees with phase")
	// Start and stop cannot land on the same transaction
	`POT_NEVER(a_start_stop, result.valid && result.data.started && result.data.stopped, "started and stopped together")
	// A start always leaves the sequence active
	`POT_ASSERT(a_start_active, (result.valid && result.data.started) |-> (result.data.phase == PH_ACTIVE), "started outside the active phase")
	// A held input moves into an empty result register
	`POT_ASSERT(a_s1_drains, (valid_s1 && !valid_s2) |=> valid_s2, "input register failed to advance")

endmodule

[rtl/core/pot_cfg.sv]
module pot_cfg #(
	parameter int PATTERN_BYTES = 8,
	parameter int DELAY_BITS    = 20
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [pot_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pot_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output pot_pkg::cfg_t                    cfg,
	output logic [DELAY_BITS-1:0]            start_delay,
	output logic [DELAY_BITS-1:0]            active_delay
);
	import pot_pkg::*;

	localparam int CW = (DELAY_BITS > DLY_W) ? DELAY_BITS : DLY_W;

	logic             mode_q;
	logic [PAT_W-1:0] start_pat_q;
	logic [LEN_W-1:0] start_len_q;
	logic [PAT_W-1:0] stop_pat_q;
	logic [LEN_W-1:0] stop_len_q;
	logic [DLY_W-1:0] start_dly_q;
	logic [DLY_W-1:0] act_dly_q;

	// Force a length into one to the window depth
	function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
		logic [LEN_W-1:0] r;
		r = len;
		if (r == '0) r = LEN_W'(1);
		if (r > LEN_W'(PATTERN_BYTES)) r = LEN_W'(PATTERN_BYTES);
		return r;
	endfunction

	// Force a delay into one to the counter maximum
	function automatic logic [DELAY_BITS-1:0] clamp_dly(input logic [DLY_W-1:0] d);
		logic [CW-1:0] dx;
		logic [CW-1:0] dmax;
		dx   = CW'(d);
		dmax = CW'({DELAY_BITS{1'b1}});
		if (dx > dmax) dx = dmax;
		if (dx == '0) dx = CW'(1);
		return DELAY_BITS'(dx);
	endfunction

	// Write the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_TIMED;
			start_pat_q <= '0;
			start_len_q <= LEN_W'(1);
			stop_pat_q  <= '0;
			stop_len_q  <= LEN_W'(1);
			start_dly_q <= DLY_W'(1);
			act_dly_q   <= DLY_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODE:        mode_q      <= cfg_wdata[0];
				REG_START_PAT:   start_pat_q <= cfg_wdata[PAT_W-1:0];
				REG_START_LEN:   start_len_q <= cfg_wdata[LEN_W-1:0];
				REG_STOP_PAT:    stop_pat_q  <= cfg_wdata[PAT_W-1:0];
				REG_STOP_LEN:    stop_len_q  <= cfg_wdata[LEN_W-1:0];
				REG_START_DELAY: start_dly_q <= cfg_wdata[DLY_W-1:0];
				REG_ACTIVE_DUR:  act_dly_q   <= cfg_wdata[DLY_W-1:0];
				default: ;
			endcase
		end
	end

	// Present the clamped view
	always_comb begin
		cfg.trigger_mode  = mode_q;
		cfg.start_pattern = start_pat_q;
		cfg.start_len     = clamp_len(start_len_q);
		cfg.stop_pattern  = stop_pat_q;
		cfg.stop_len      = clamp_len(stop_len_q);
	end

	assign start_delay  = clamp_dly(start_dly_q);
	assign active_delay = clamp_dly(act_dly_q);

endmodule

[rtl/core/pot_window.sv]
module pot_window #(
	parameter int PATTERN_BYTES = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pot_pkg::win_ctl_t ctl,
	input  logic [7:0]        rx_byte,
	input  pot_pkg::cfg_t     cfg,
	output pot_pkg::win_hit_t hit
);
	import pot_pkg::*;

	localparam int WIN_W = 8 * PATTERN_BYTES;

	logic [WIN_W-1:0] win_q;
	logic [LEN_W-1:0] fill_q;
	logic [WIN_W-1:0] win_shift;
	logic [LEN_W-1:0] fill_next;

	// Newest byte at the bottom, the oldest falls off the top
	assign win_shift = WIN_W'({win_q, rx_byte});
	assign fill_next = (fill_q < LEN_W'(PATTERN_BYTES)) ? fill_q + LEN_W'(1) : fill_q;

	// Compare the newest len bytes with the first len pattern characters
	function automatic logic match(
		input logic [WIN_W-1:0] w,
		input logic [LEN_W-1:0] fill,
		input logic [PAT_W-1:0] pat,
		input logic [LEN_W-1:0] len
	);
		logic [PAT_W-1:0] rev;
		logic [PAT_W-1:0] aligned;
		logic [2:0]       sh;
		logic             ok;
		for (int i = 0; i < 8; i++) begin
			rev[8*i +: 8] = pat[8*(7-i) +: 8];
		end
		sh      = 3'(LEN_W'(8) - len);
		aligned = rev >> {sh, 3'b000};
		ok      = (fill >= len);
		for (int j = 0; j < PATTERN_BYTES; j++) begin
			if ((LEN_W'(j) < len) && (w[8*j +: 8] != aligned[8*j +: 8])) ok = 1'b0;
		end
		return ok;
	endfunction

	assign hit.start_hit = match(win_shift, fill_next, cfg.start_pattern, cfg.start_len);
	assign hit.stop_hit  = match(win_shift, fill_next, cfg.stop_pattern, cfg.stop_len);

	// Clear, shift in or hold the window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q  <= '0;
			fill_q <= '0;
		end else if (ctl.clear) begin
			win_q  <= '0;
			fill_q <= '0;
		end else if (ctl.shift) begin
			win_q  <= win_shift;
			fill_q <= fill_next;
		end
	end

endmodule

[rtl/core/pot_ctrl.sv]
module pot_ctrl #(
	parameter int DELAY_BITS = 20
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  advance,
	input  pot_pkg::in_item_t     item,
	input  logic                  trigger_mode,
	input  logic [DELAY_BITS-1:0] start_delay,
	input  logic [DELAY_BITS-1:0] active_delay,
	input  pot_pkg::win_hit_t     hit,
	output pot_pkg::win_ctl_t     win_ctl,
	output pot_pkg::out_item_t    result
);
	import pot_pkg::*;

	logic [1:0]            phase_q;
	logic [DELAY_BITS-1:0] tick_q;
	logic                  pulse_q;

	logic [1:0]            phase_d;
	logic [DELAY_BITS-1:0] tick_d;
	logic                  pulse_d;
	logic                  started;
	logic                  stopped;
	logic                  shift;
	logic                  clr;
	logic [DELAY_BITS:0]   tick_inc;

	assign tick_inc = {1'b0, tick_q} + (DELAY_BITS+1)'(1);

	// Work out the next phase and the flags for this transaction
	always_comb begin
		phase_d = phase_q;
		tick_d  = tick_q;
		pulse_d = pulse_q;
		started = 1'b0;
		stopped = 1'b0;
		shift   = 1'b0;
		clr     = 1'b0;
		unique case (item.cmd)
			CMD_BYTE: begin
				if (trigger_mode == MODE_SERIAL &&
				    (phase_q == PH_WAIT || phase_q == PH_ACTIVE)) begin
					shift = 1'b1;
					if (phase_q == PH_WAIT) begin
						if (hit.start_hit) begin
							pulse_d = 1'b1;
							phase_d = PH_ACTIVE;
							started = 1'b1;
							clr     = 1'b1;
						end
					end else if (hit.stop_hit) begin
						pulse_d = 1'b0;
						phase_d = PH_DONE;
						stopped = 1'b1;
					end
				end
			end
			CMD_TICK: begin
				if (trigger_mode == MODE_TIMED) begin
					unique case (phase_q)
						PH_WAIT: begin
							if (item.power_sensed) begin
								phase_d = PH_DELAY;
								tick_d  = '0;
							end
						end
						PH_DELAY: begin
							tick_d = tick_inc[DELAY_BITS-1:0];
							if (tick_inc >= {1'b0, start_delay}) begin
								pulse_d = 1'b1;
								phase_d = PH_ACTIVE;
								started = 1'b1;
								tick_d  = '0;
							end
						end
						PH_ACTIVE: begin
							tick_d = tick_inc[DELAY_BITS-1:0];
							if (tick_inc >= {1'b0, active_delay}) begin
								pulse_d = 1'b0;
								phase_d = PH_DONE;
								stopped = 1'b1;
								tick_d  = '0;
							end
						end
						default: ;
					endcase
				end
			end
			CMD_REARM: begin
				stopped = pulse_q;
				pulse_d = 1'b0;
				phase_d = PH_WAIT;
				tick_d  = '0;
				clr     = 1'b1;
			end
			default: ;
		endcase
	end

	assign win_ctl.shift = advance & shift;
	assign win_ctl.clear = advance & clr;

	always_comb begin
		result.pulse_active = pulse_d;
		result.phase        = phase_d;
		result.started      = started;
		result.stopped      = stopped;
	end

	// Advance the sequence state on each transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT;
			tick_q  <= '0;
			pulse_q <= 1'b0;
		end else if (advance) begin
			phase_q <= phase_d;
			tick_q  <= tick_d;
			pulse_q <= pulse_d;
		end
	end

endmodule

[tb/tb_pattern_or_timed_pulse_trigger.sv]
package trigger_tb_pkg;
	import pot_pkg::*;

	localparam int WINDOW_BYTES = 8;

	// Tracks the trigger sequence and holds the results still owed by the block
	class trigger_tracker;
		logic             mode;
		logic [PAT_W-1:0] start_pat;
		logic [PAT_W-1:0] stop_pat;
		logic [LEN_W-1:0] start_len;
		logic [LEN_W-1:0] stop_len;
		logic [DLY_W-1:0] start_dly;
		logic [DLY_W-1:0] active_dly;
		logic [PAT_W-1:0] window;
		logic [3:0]       fill;
		logic [1:0]       phase;
		logic [DLY_W-1:0] ticks;
		logic             pulse;
		out_item_t        owed_results[$];
		int unsigned      fail_count;

		function new();
			mode       = MODE_TIMED;
			start_pat  = '0;
			stop_pat   = '0;
			start_len  = 1;
			stop_len   = 1;
			start_dly  = 1;
			active_dly = 1;
			window     = '0;
			fill       = '0;
			phase      = PH_WAIT;
			ticks      = '0;
			pulse      = 1'b0;
			fail_count = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
			case (idx)
				REG_MODE:        mode = value[0];
				REG_START_PAT:   start_pat = value;
				REG_START_LEN:   start_len = value[LEN_W-1:0];
				REG_STOP_PAT:    stop_pat = value;
				REG_STOP_LEN:    stop_len = value[LEN_W-1:0];
				REG_START_DELAY: start_dly = value[DLY_W-1:0];
				REG_ACTIVE_DUR:  active_dly = value[DLY_W-1:0];
				default: ;
			endcase
		endfunction

		// Compare the newest bytes with a pattern, oldest byte against character zero
		function bit window_hit(logic [PAT_W-1:0] pat, logic [LEN_W-1:0] len_reg);
			int n;
			n = (len_reg == 0) ? 1 : ((len_reg > WINDOW_BYTES) ? WINDOW_BYTES : int'(len_reg));
			if (fill < n)
				return 1'b0;
			for (int k = 0; k < n; k++)
				if (window[8*(n-1-k) +: 8] != pat[8*k +: 8])
					return 1'b0;
			return 1'b1;
		endfunction

		// A zero delay counts as one tick
		function bit delay_done(logic [DLY_W-1:0] d);
			return ticks >= ((d == 0) ? DLY_W'(1) : d);
		endfunction

		// Advance the sequence by one accepted transaction and queue its result
		function void note_item(in_item_t it);
			out_item_t r;
			r = '0;
			case (it.cmd)
				CMD_BYTE: begin
					if (mode == MODE_SERIAL && (phase == PH_WAIT || phase == PH_ACTIVE)) begin
						window = {window[PAT_W-9:0], it.rx_byte};
						if (fill < WINDOW_BYTES)
							fill++;
						if (phase == PH_WAIT) begin
							if (window_hit(start_pat, start_len)) begin
								pulse     = 1'b1;
								phase     = PH_ACTIVE;
								r.started = 1'b1;
								window    = '0;
								fill      = '0;
							end
						end else if (window_hit(stop_pat, stop_len)) begin
							pulse     = 1'b0;
							phase     = PH_DONE;
							r.stopped = 1'b1;
						end
					end
				end
				CMD_TICK: begin
					if (mode == MODE_TIMED) begin
						case (phase)
							PH_WAIT: begin
								if (it.power_sensed) begin
									phase = PH_DELAY;
									ticks = '0;
								end
							end
							PH_DELAY: begin
								ticks++;
								if (delay_done(start_dly)) begin
									pulse     = 1'b1;
									phase     = PH_ACTIVE;
									r.started = 1'b1;
									ticks     = '0;
								end
							end
							PH_ACTIVE: begin
								ticks++;
								if (delay_done(active_dly)) begin
									pulse     = 1'b0;
									phase     = PH_DONE;
									r.stopped = 1'b1;
									ticks     = '0;
								end
							end
							default: ;
						endcase
					end
				end
				CMD_REARM: begin
					r.stopped = pulse;
					pulse     = 1'b0;
					phase     = PH_WAIT;
					window    = '0;
					fill      = '0;
					ticks     = '0;
				end
				default: ;
			endcase
			r.pulse_active = pulse;
			r.phase        = phase;
			owed_results.push_back(r);
		endfunction

		function void compare_field(string name, logic [1:0] want, logic [1:0] got,
				time stamp);
			if (want !== got) begin
				$display("%0d ns: %s expected %0d, got %0d", stamp, name, want, got);
				fail_count++;
			end
		endfunction

		// Check one accepted result against the oldest one owed
		function void check_result(out_item_t got, time stamp);
			out_item_t want;
			if (owed_results.size() == 0) begin
				$display("%0d ns: result expected none, got pulse_active %0d phase %0d",
					stamp, got.pulse_active, got.phase);
				fail_count++;
				return;
			end
			want = owed_results.pop_front();
			compare_field("pulse_active", want.pulse_active, got.pulse_active, stamp);
			compare_field("phase", want.phase, got.phase, stamp);
			compare_field("started", want.started, got.started, stamp);
			compare_field("stopped", want.stopped, got.stopped, stamp);
		endfunction

		function int pending();
			return owed_results.size();
		endfunction
	endclass

endpackage

module tb_pattern_or_timed_pulse_trigger;
	timeunit 1ns;
	timeprecision 1ps;

	import pot_pkg::*;
	import trigger_tb_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int ROUNDS      = 16;
	localparam int ROUND_ITEMS = 83;
	localparam int HOLD_CYCLES = 50;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	pot_in_if  item_ch ();
	pot_out_if result_ch ();

	trigger_tracker tracker;
	int             sender_idle_pct;
	int             receiver_stall_pct;
	int             hold_req;
	int             items_sent;

	pattern_or_timed_pulse_trigger u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.item      (item_ch),
		.result    (result_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Observe both channels on the pre-edge values
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_ch.valid && item_ch.ready)
				tracker.note_item(item_ch.data);
			if (result_ch.valid && result_ch.ready)
				tracker.check_result(result_ch.data, $time);
		end
	end

	// Result side: random stalls, plus a long hold-off on each request
	initial begin : receiver
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				result_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
			end
		end
	end

	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic in_item_t make_item(logic [1:0] c, logic [7:0] b, logic p);
		in_item_t it;
		it.cmd          = c;
		it.rx_byte      = b;
		it.power_sensed = p;
		return it;
	endfunction

	function automatic int span(logic [LEN_W-1:0] l);
		return (l == 0) ? 1 : ((l > WINDOW_BYTES) ? WINDOW_BYTES : int'(l));
	endfunction

	// Offer one transaction, idling first at random, and hold until accepted
	task automatic send_item(in_item_t it);
		while ($urandom_range(99) < sender_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.data  <= it;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		items_sent++;
	endtask

	// Send the first n characters of a pattern, oldest first
	task automatic send_pattern(logic [PAT_W-1:0] pat, int n);
		for (int k = 0; k < n; k++)
			send_item(make_item(CMD_BYTE, pat[8*k +: 8], 1'($urandom)));
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		tracker.set_reg(idx, value);
	endtask

	// Drop valid and wait for every owed result, then for the pipeline to empty
	task automatic settle();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		bit                    serial;
		bit                    held;
		int                    pick;
		int                    n;
		int                    pos;
		int                    first;
		logic [7:0]            noise;
		logic [PAT_W-1:0]      start_pat;
		logic [PAT_W-1:0]      stop_pat;
		logic [CFG_DATA_W-1:0] v;
		logic [CFG_DATA_W-1:0] start_len_w;
		logic [CFG_DATA_W-1:0] stop_len_w;
		logic [CFG_DATA_W-1:0] start_dly_w;
		logic [CFG_DATA_W-1:0] active_dly_w;

		tracker            = new();
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = '0;
		cfg_wdata          = '0;
		item_ch.valid      = 1'b0;
		item_ch.data       = '0;
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		hold_req           = 0;
		items_sent         = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Timed sequence on reset settings: ignored bytes, done phase, unknown command, rearms
		send_item(make_item(CMD_TICK, 8'h00, 1'b0));
		send_item(make_item(CMD_BYTE, 8'h00, 1'b1));
		send_item(make_item(CMD_TICK, 8'hFF, 1'b1));
		send_item(make_item(CMD_TICK, 8'h5A, 1'b0));
		send_item(make_item(CMD_BYTE, 8'hFF, 1'b0));
		send_item(make_item(CMD_TICK, 8'h00, 1'b0));
		send_item(make_item(CMD_TICK, 8'hFF, 1'b1));
		send_item(make_item(CMD_UNUSED, 8'hA5, 1'b1));
		send_item(make_item(CMD_REARM, 8'h00, 1'b0));
		send_item(make_item(CMD_TICK, 8'h00, 1'b1));
		send_item(make_item(CMD_TICK, 8'h00, 1'b0));
		send_item(make_item(CMD_REARM, 8'hFF, 1'b1));
		settle();

		// Zero start delay behaves as one tick; leave the output active
		write_reg(REG_START_DELAY, 64'hFFFF_FFFF_FFF0_0000);
		write_reg(REG_ACTIVE_DUR, 64'd3);
		cfg_we <= 1'b0;
		send_item(make_item(CMD_TICK, 8'h00, 1'b1));
		send_item(make_item(CMD_TICK, 8'h00, 1'b0));
		send_item(make_item(CMD_TICK, 8'h00, 1'b0));
		settle();

		// Switch to serial while active: an oversized stop length clamps to the full window
		write_reg(REG_MODE, 64'(MODE_SERIAL));
		write_reg(REG_STOP_PAT, 64'h00FF_00FF_00FF_00FF);
		write_reg(REG_STOP_LEN, 64'hF);
		cfg_we <= 1'b0;
		send_pattern(64'h00FF_00FF_00FF_00FF, WINDOW_BYTES);
		send_item(make_item(CMD_BYTE, 8'h42, 1'b0));
		settle();

		for (int round = 0; round < ROUNDS; round++) begin
			serial = 1'(((round >> 2) ^ round) & 1);
			case (round % 4)
				0: begin
					sender_idle_pct = 0;
					receiver_stall_pct <= 0;
				end
				1: begin
					sender_idle_pct = 69;
					receiver_stall_pct <= 0;
				end
				2: begin
					sender_idle_pct = 0;
					receiver_stall_pct <= 69;
				end
				default: begin
					sender_idle_pct = 12;
					receiver_stall_pct <= 12;
				end
			endcase

			// Patterns: random, one repeated byte, shared start and stop, or all zeros and ones
			start_pat = {$urandom, $urandom};
			stop_pat  = {$urandom, $urandom};
			case ($urandom_range(3))
				1: begin
					start_pat = {8{8'($urandom)}};
					stop_pat  = {8{8'($urandom)}};
				end
				2: stop_pat = start_pat;
				3: begin
					start_pat = '0;
					stop_pat  = '1;
				end
				default: ;
			endcase

			if (round == 1) begin
				start_len_w = 64'd1;
				stop_len_w  = 64'd1;
			end else if (round == 3) begin
				start_len_w = 64'd8;
				stop_len_w  = 64'd8;
			end else if (round == 4) begin
				start_len_w = '0;
				stop_len_w  = 64'hF;
			end else begin
				start_len_w = {$urandom, $urandom};
				stop_len_w  = {$urandom, $urandom};
			end

			case (round)
				0: begin
					start_dly_w  = 64'hFFFF_FFFF_FFF0_0000;
					active_dly_w = '0;
				end
				2: begin
					start_dly_w  = 64'hF_FFFF;
					active_dly_w = 64'hF_FFFF;
				end
				5: begin
					start_dly_w  = 64'd1;
					active_dly_w = 64'd1;
				end
				default: begin
					start_dly_w  = {$urandom, $urandom};
					active_dly_w = {$urandom, $urandom};
					start_dly_w[DLY_W-1:0]  = DLY_W'($urandom_range(6, 1));
					active_dly_w[DLY_W-1:0] = DLY_W'($urandom_range(6, 0));
				end
			endcase

			v    = {$urandom, $urandom};
			v[0] = serial ? MODE_SERIAL : MODE_TIMED;
			write_reg(REG_MODE, v);
			write_reg(REG_START_PAT, start_pat);
			write_reg(REG_START_LEN, start_len_w);
			write_reg(REG_STOP_PAT, stop_pat);
			write_reg(REG_STOP_LEN, stop_len_w);
			write_reg(REG_START_DELAY, start_dly_w);
			write_reg(REG_ACTIVE_DUR, active_dly_w);
			cfg_we <= 1'b0;

			first = items_sent;
			held  = 1'b0;
			while (items_sent < first + ROUND_ITEMS) begin
				// Hold the result side off mid-round so the input stalls
				if (!held && items_sent >= first + ROUND_ITEMS / 2) begin
					hold_req <= hold_req + 1;
					held = 1'b1;
				end
				pick = $urandom_range(99);
				if (serial) begin
					if (pick < 35) begin
						n = span(start_len_w[LEN_W-1:0]);
						if (n > 1 && $urandom_range(5) == 0)
							n = $urandom_range(n - 1, 1);
						send_pattern(start_pat, n);
					end else if (pick < 62) begin
						n = span(stop_len_w[LEN_W-1:0]);
						if (n > 1 && $urandom_range(5) == 0)
							n = $urandom_range(n - 1, 1);
						send_pattern(stop_pat, n);
					end else if (pick < 80) begin
						// Stray byte, often one taken from a pattern
						noise = 8'($urandom);
						if ($urandom_range(1) == 1) begin
							pos   = $urandom_range(7);
							noise = ($urandom_range(1) == 1) ? stop_pat[8*pos +: 8]
								: start_pat[8*pos +: 8];
						end
						send_item(make_item(CMD_BYTE, noise, 1'($urandom)));
					end else if (pick < 88) begin
						send_item(make_item(CMD_REARM, 8'($urandom), 1'($urandom)));
					end else if (pick < 94) begin
						send_item(make_item(CMD_TICK, 8'($urandom), 1'($urandom)));
					end else begin
						send_item(make_item(CMD_UNUSED, 8'($urandom), 1'($urandom)));
					end
				end else begin
					if (pick < 70)
						send_item(make_item(CMD_TICK, 8'($urandom),
							1'($urandom_range(99) < 70)));
					else if (pick < 77)
						send_item(make_item(CMD_REARM, 8'($urandom), 1'($urandom)));
					else if (pick < 92)
						send_item(make_item(CMD_BYTE, 8'($urandom), 1'($urandom)));
					else
						send_item(make_item(CMD_UNUSED, 8'($urandom), 1'($urandom)));
				end
			end
			settle();
		end

		if (tracker.fail_count == 0 && tracker.pending() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/pot_pkg.sv
rtl/core/pot_if.sv
rtl/core/pot_cfg.sv
rtl/core/pot_window.sv
rtl/core/pot_ctrl.sv
rtl/core/pattern_or_timed_pulse_trigger.sv
tb/tb_pattern_or_timed_pulse_trigger.sv
